// ----- hw/rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

    typedef logic [CFG_W-1:0] t_cfg_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
    } t_out_item;

    // one deque candidate as held by or passed between cells
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
    } t_link;

endpackage

// ----- hw/rtl/swm_chan_if.sv -----
// ----------------------------------------------------------------------------
// swm_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface swm_chan_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- hw/rtl/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the candidate chain: holds the sample of a fixed age and
// passes it on to the next older slot if it stays a candidate.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
    parameter int AGE = 1,
    parameter int AW  = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_clear,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [AW-1:0]              i_win,
    input  t_link                      i_link,
    output t_link                      o_link,
    output t_link                      o_state
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_value;
    logic                       keep;

    // drop when not greater than the new sample, out of the window or on a sequence start
    assign keep = r_valid && !i_clear && (r_value > i_sample) && (AW'(AGE) < i_win);

    assign o_link  = '{valid: keep, value: r_value};
    assign o_state = '{valid: r_valid, value: r_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_link.value;
        end
    end

endmodule

// ----- hw/rtl/swm_max_tree.sv -----
// ----------------------------------------------------------------------------
// swm_max_tree
// Registered selection tree picking the oldest valid candidate, which is
// the window maximum since candidate values fall with decreasing age.
// ----------------------------------------------------------------------------
module swm_max_tree import swm_pkg::*; #(
    parameter int LEAVES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_tag,
    input  t_link i_leaf [LEAVES],
    output t_link o_root,
    output logic  o_valid
);

    localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int NPAD   = 1 << LEVELS;

    t_link       w_node [1:2*NPAD-1];
    t_link       r_node [1:NPAD-1];
    logic [LEVELS:0] r_tag;

    genvar k;
    generate
        for (k = 0; k < NPAD; k++) begin : g_leaf
            if (k < LEAVES) begin : g_used
                assign w_node[NPAD+k] = i_leaf[k];
            end else begin : g_pad
                assign w_node[NPAD+k] = '{valid: 1'b0, value: '0};
            end
        end

        // higher leaf index is older, older valid wins
        for (k = 1; k < NPAD; k++) begin : g_node
            assign w_node[k] = r_node[k];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_node[k].valid <= 1'b0;
                end else if (i_en) begin
                    r_node[k] <= w_node[2*k+1].valid ? w_node[2*k+1] : w_node[2*k];
                end
            end
        end
    endgenerate

    // result flag travels alongside the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= {r_tag[LEVELS-1:0], i_tag};
        end
    end

    assign o_root  = w_node[1];
    assign o_valid = r_tag[LEVELS];

endmodule

// ----- hw/rtl/sliding_window_maximum_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_top
// Maximum of the last window_size signed samples over a stream.
//
//   channel  dir  payload                 note
//   i_in     in   sample[31:0], first     one sample per item
//   o_res    out  window_max[31:0]        zero or one item per sample
//   i_cfg    in   window_size[6:0]        always ready
//
// one sample is taken per cycle while the result does not stall; a result passes
// the candidate chain and then each registered level of the selection tree
// reset clears the candidate chain, the counters and sets window_size to 1
// a stalled result holds the whole pipeline and input ready drops
// ----------------------------------------------------------------------------
module sliding_window_maximum_top import swm_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swm_chan_if.sink   i_in,
    swm_chan_if.source o_res,
    swm_chan_if.sink   i_cfg
);

    localparam int AW   = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = (AW > CFG_W) ? AW : CFG_W;

    t_cfg_word       r_window;
    logic [CMPW-1:0] ws_ext;
    logic [AW-1:0]   w_eff;
    logic [AW-1:0]   r_seen;
    logic [AW-1:0]   n_seen;
    logic            en;
    logic            acc;
    logic            emit;
    t_in_item        in_item;
    t_link           w_link  [WINDOW_MAX+1];
    t_link           w_state [WINDOW_MAX];
    t_link           w_root;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            r_window <= i_cfg.payload;
        end
    end

    assign ws_ext = CMPW'(r_window);
    assign w_eff  = (ws_ext > CMPW'(WINDOW_MAX)) ? AW'(WINDOW_MAX) : AW'(ws_ext);

    assign in_item    = i_in.payload;
    assign en         = !o_res.valid || o_res.ready;
    assign i_in.ready = en;
    assign acc        = i_in.valid && en;

    always_comb begin
        if (in_item.first) begin
            n_seen = AW'(1);
        end else if (r_seen == AW'(WINDOW_MAX)) begin
            n_seen = r_seen;
        end else begin
            n_seen = r_seen + AW'(1);
        end
    end

    assign emit = (w_eff != '0) && (n_seen >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (acc) begin
            r_seen <= n_seen;
        end
    end

    // newest sample enters the chain at the young end
    assign w_link[0] = '{valid: 1'b1, value: in_item.sample};

    genvar j;
    generate
        for (j = 0; j < WINDOW_MAX; j++) begin : g_cell
            swm_cell #(
                .AGE (j + 1),
                .AW  (AW)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (acc),
                .i_clear  (in_item.first),
                .i_sample (in_item.sample),
                .i_win    (w_eff),
                .i_link   (w_link[j]),
                .o_link   (w_link[j+1]),
                .o_state  (w_state[j])
            );
        end
    endgenerate

    swm_max_tree #(
        .LEAVES (WINDOW_MAX)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (acc && emit),
        .i_leaf  (w_state),
        .o_root  (w_root),
        .o_valid (o_res.valid)
    );

    assign o_res.payload = '{window_max: w_root.value};

    a_chain_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_link[WINDOW_MAX].valid)
        else $error("candidate kept past the oldest cell");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= AW'(WINDOW_MAX))
        else $error("seen count beyond window limit");

    a_first_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && in_item.first |=> r_seen == AW'(1))
        else $error("sequence start did not restart the count");

    a_newest_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> w_state[0].valid)
        else $error("accepted item missing from the chain");

    a_result_has_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> w_root.valid)
        else $error("result without a front candidate");

endmodule

// ----- dv/tb_sliding_window_maximum_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum_top
// Self-checking bench for the sliding window maximum block. A scoreboard
// class keeps its own candidate deque and predicts every window maximum
// from the accepted samples. Results are compared in order. The run starts
// with directed samples and then runs random sequences under several window
// sizes. Both sides idle at random, and the receiver stalls once for a long
// stretch so that input ready drops.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum_top import swm_pkg::*; ();

    localparam int WIN_CAP      = 64;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 175;
    localparam int IDLE_PCT     = 34;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum int {
        SEQ_RANDOM,
        SEQ_SMALL,
        SEQ_FALLING,
        SEQ_RISING,
        SEQ_EXTREME
    } t_seq_style;

    class window_max_board;
        logic signed [SAMPLE_W-1:0] cand_val [WIN_CAP];
        logic [31:0]                cand_pos [WIN_CAP];
        int unsigned                head;
        int unsigned                tail;
        int unsigned                occ;
        int unsigned                seen;
        logic [31:0]                next_pos;
        t_cfg_word                  window_size;
        t_out_item                  pending_max [$];
        int                         errors;

        function new();
            int i;
            for (i = 0; i < WIN_CAP; i++) begin
                cand_val[i] = '0;
                cand_pos[i] = '0;
            end
            head        = 0;
            tail        = 0;
            occ         = 0;
            seen        = 0;
            next_pos    = '0;
            window_size = WINDOW_RESET;
            errors      = 0;
        endfunction

        function void set_window(t_cfg_word v);
            window_size = v;
        endfunction

        function void take_sample(t_in_item it);
            int unsigned                w;
            logic signed [SAMPLE_W-1:0] x;
            logic [31:0]                p;
            t_out_item                  res;
            x = it.sample;
            w = (window_size > WIN_CAP) ? WIN_CAP : window_size;
            if (it.first) begin
                head     = 0;
                tail     = 0;
                occ      = 0;
                next_pos = '0;
                seen     = 0;
            end
            p = next_pos;
            // drop back entries not greater than the new sample
            while (occ > 0 && cand_val[(tail + WIN_CAP - 1) % WIN_CAP] <= x) begin
                tail = (tail + WIN_CAP - 1) % WIN_CAP;
                occ--;
            end
            // drop front entries that left the window
            while (occ > 0 && (p - cand_pos[head]) >= w) begin
                head = (head + 1) % WIN_CAP;
                occ--;
            end
            if (occ >= WIN_CAP) begin
                head = (head + 1) % WIN_CAP;
                occ--;
            end
            cand_val[tail] = x;
            cand_pos[tail] = p;
            tail = (tail + 1) % WIN_CAP;
            occ++;
            next_pos = p + 1;
            if (seen < WIN_CAP)
                seen++;
            if (w > 0 && seen >= w) begin
                res.window_max = cand_val[head];
                pending_max.insert(pending_max.size(), res);
            end
        endfunction

        function void check_max(t_out_item got);
            t_out_item want;
            if (pending_max.size() == 0) begin
                errors++;
                $display("%0t: unexpected window_max, expected none, actual %0d",
                         $time, got.window_max);
            end else begin
                want = pending_max[0];
                pending_max.delete(0);
                if (got.window_max !== want.window_max) begin
                    errors++;
                    $display("%0t: window_max mismatch, expected %0d, actual %0d",
                             $time, want.window_max, got.window_max);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_chan_if #(.t_payload(t_in_item))  in_ch ();
    swm_chan_if #(.t_payload(t_out_item)) res_ch ();
    swm_chan_if #(.t_payload(t_cfg_word)) cfg_ch ();

    sliding_window_maximum_top #(
        .WINDOW_MAX (WIN_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    window_max_board board;
    bit              calm;
    bit              hold_req;
    t_cfg_word       cur_window;
    int              seq_left;
    t_seq_style      style;
    logic [31:0]     ramp;
    int              idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                board.take_sample(in_ch.payload);
            if (res_ch.valid && res_ch.ready)
                board.check_max(res_ch.payload);
            if (cfg_ch.valid && cfg_ch.ready)
                board.set_window(cfg_ch.payload);
        end
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side, with one long hold-off
    initial begin : res_side
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (calm) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic f);
        t_in_item it;
        it.sample = s;
        it.first  = f;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_max.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input t_cfg_word v);
        drain();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= v;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_window = v;
    endtask

    task automatic next_item(output t_in_item it);
        int unsigned w_eff;
        w_eff = (cur_window > WIN_CAP) ? WIN_CAP : cur_window;
        it.first = 1'b0;
        if (seq_left <= 0) begin
            seq_left = $urandom_range(1, 2 * w_eff + 8);
            style    = t_seq_style'($urandom_range(0, 4));
            ramp     = $urandom;
            it.first = 1'b1;
        end
        seq_left--;
        // stray start markers
        if ($urandom_range(0, 99) < 6)
            it.first = 1'($urandom_range(0, 1));
        case (style)
            SEQ_RANDOM: begin
                it.sample = $urandom;
            end
            SEQ_SMALL: begin
                it.sample = $urandom_range(0, 8) - 4;
            end
            SEQ_FALLING: begin
                ramp      = ramp - $urandom_range(0, 2);
                it.sample = ramp;
            end
            SEQ_RISING: begin
                ramp      = ramp + $urandom_range(0, 2);
                it.sample = ramp;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: it.sample = S_MAX;
                    1: it.sample = S_MIN;
                    2: it.sample = '0;
                    3: it.sample = '1;
                    4: it.sample = 1;
                    default: it.sample = $urandom;
                endcase
            end
        endcase
    endtask

    initial begin : stimulus
        t_in_item  it;
        t_cfg_word w;
        int        ph;
        int        n;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.payload  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        calm       = 1'b1;
        hold_req   = 1'b0;
        seq_left   = 0;
        style      = SEQ_RANDOM;
        ramp       = '0;
        cur_window = WINDOW_RESET;
        board      = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window of one after reset
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        // equal values and expiry from the front
        write_window(7'd3);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(-5, 1'b0);
        send_sample(-5, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(-9, 1'b0);
        // window shrinks mid-sequence
        write_window(7'd2);
        send_sample(3, 1'b0);
        send_sample(-1, 1'b0);
        // zero window
        write_window(7'd0);
        send_sample(7, 1'b1);
        send_sample(8, 1'b0);
        send_sample(-3, 1'b0);
        // window above capacity, then set to capacity mid-sequence
        write_window(7'd127);
        send_sample(1, 1'b1);
        send_sample(2, 1'b0);
        write_window(7'd64);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        calm = 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: w = 7'd64;
                1: w = 7'd1;
                2: w = 7'd127;
                3: w = 7'd0;
                4: w = 7'd2;
                7: w = 7'd100;
                9: w = 7'd3;
                default: w = t_cfg_word'($urandom_range(1, 70));
            endcase
            write_window(w);
            calm = (ph == 1);
            if ($urandom_range(0, 1))
                seq_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 40)
                    hold_req = 1'b1;
                next_item(it);
                send_sample(it.sample, it.first);
            end
        end

        drain();
        if (board.errors == 0 && board.pending_max.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/swm_pkg.sv
hw/rtl/swm_chan_if.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_max_tree.sv
hw/rtl/sliding_window_maximum_top.sv
dv/tb_sliding_window_maximum_top.sv
